// File: src/gregorian_date_to_year_day_unit_macros.svh
// assertion macros for the date conversion checker
`ifndef GREGORIAN_DATE_TO_YEAR_DAY_UNIT_MACROS_SVH
`define GREGORIAN_DATE_TO_YEAR_DAY_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define GDYD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gdyd check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define GDYD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gdyd check failed");

`endif

// File: src/gdyd_pkg.sv
// types, constants and tables shared by the date conversion pipeline
`default_nettype none
package gdyd_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_YEAR  = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_BAD_DAY   = 2'd3
  } status_e;

  localparam int JD_W  = 24;
  localparam int KP_W  = 16;
  localparam int Q_W   = 9;
  localparam int K2_W  = 14;
  localparam int L_W   = 11;

  localparam int MONTH_JAN     = 1;
  localparam int MONTH_FEB     = 2;
  localparam int MONTH_DEC     = 12;
  localparam int FEB_LEAP_DAYS = 29;

  localparam int YEAR_MIN      = -4711;
  localparam int TWO_DIGIT_MAX = 99;
  localparam int CENT_SPLIT    = 50;
  localparam int BASE_2000     = 2000;
  localparam int BASE_1900     = 1900;

  localparam int YEAR_OFFSET = 4800;
  localparam int HUNDRED     = 100;
  localparam int CYC4_DAYS   = 1461;
  localparam int YEAR_DAYS   = 365;
  localparam int JD_OFFSET   = 30660;
  localparam int EPOCH_YEAR  = 4716;
  localparam int DAY_BASE    = 59;
  localparam int MONTH_SHIFT = 30;
  localparam int T_MUL       = 80;
  localparam int T_LIMIT     = 11 * 2447;

  localparam int DIV100_SHIFT = 23;
  localparam int DIV100_MUL   = ((1 << DIV100_SHIFT) + HUNDRED - 1) / HUNDRED;

  localparam int             DIV1461_SHIFT = 35;
  localparam longint unsigned DIV1461_MUL  =
    ((64'd1 << DIV1461_SHIFT) + 64'(CYC4_DAYS) - 64'd1) / 64'(CYC4_DAYS);
  localparam int             DIV1461_PW    = 49;

  typedef struct packed {
    logic [JD_W-1:0] jd;
    status_e         status;
  } jdn_word_t;

  // 367 * (m - 2 + 12 * a) / 12
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/gdyd_in_if.sv
// date word channel
`default_nettype none
interface gdyd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] greg_year;
  logic [3:0]         greg_month;
  logic [4:0]         greg_day;

  modport source (output valid, greg_year, greg_month, greg_day, input ready);
  modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
endinterface
`default_nettype wire

// File: src/gdyd_out_if.sv
// result word channel
`default_nettype none
interface gdyd_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] aligned_year;
  logic [8:0]         day_of_year;
  logic [1:0]         status;

  modport source (output valid, aligned_year, day_of_year, status, input ready);
  modport sink   (input valid, aligned_year, day_of_year, status, output ready);
endinterface
`default_nettype wire

// File: src/gdyd_jdn.sv
// first three stages: checks and gregorian date to day number
`default_nettype none
module gdyd_jdn
  import gdyd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cen_i,
  gdyd_in_if.sink        date_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output jdn_word_t      out_word_o
);

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // stage 0 logic
  logic signed [16:0] y_s, yadj_s, yp_s;
  logic               bad_year, bad_month, a0;
  logic [KP_W-1:0]    yp0, kp0;
  status_e            st0;

  // stage 1 registers
  logic [KP_W-1:0] yp1_q, kp1_q;
  logic [3:0]      m1_q;
  logic [4:0]      d1_q;
  status_e         st1_q;

  // stage 1 logic
  logic [25:0] t1;
  logic [32:0] prod_k, prod_y;

  // stage 2 registers
  logic [25:0]     t1_2_q;
  logic [Q_W-1:0]  qk2_q, qy2_q;
  logic [KP_W-1:0] yp2_q;
  logic [8:0]      mt2_q;
  logic [4:0]      ml2_q;
  logic [3:0]      m2_q;
  logic [4:0]      d2_q;
  status_e         st2_q;

  // stage 2 logic
  logic        div100, leap, bad_day;
  logic [4:0]  mlen_eff;
  logic [10:0] c_inc, c_x3;
  logic [24:0] jd_w;
  status_e     st_fin;

  jdn_word_t   w3_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign date_i.ready = en1;

  always_comb begin
    y_s    = 17'(date_i.greg_year);
    yadj_s = y_s;
    if (cen_i) begin
      if (y_s >= 17'sd0 && y_s < 17'(CENT_SPLIT)) begin
        yadj_s = y_s + 17'(BASE_2000);
      end else if (y_s >= 17'(CENT_SPLIT) && y_s <= 17'(TWO_DIGIT_MAX)) begin
        yadj_s = y_s + 17'(BASE_1900);
      end
    end
    bad_year  = yadj_s < 17'(YEAR_MIN);
    bad_month = (date_i.greg_month == 4'd0) || (date_i.greg_month > 4'(MONTH_DEC));
    if (bad_year) begin
      st0 = ST_BAD_YEAR;
    end else if (bad_month) begin
      st0 = ST_BAD_MONTH;
    end else begin
      st0 = ST_OK;
    end
    a0   = (date_i.greg_month == 4'(MONTH_JAN)) || (date_i.greg_month == 4'(MONTH_FEB));
    yp_s = yadj_s + 17'(YEAR_OFFSET);
    yp0  = yp_s[KP_W-1:0];
    kp0  = yp0 - KP_W'(a0);
  end

  always_comb begin
    t1     = 26'(kp1_q) * 26'(CYC4_DAYS);
    prod_k = 33'(kp1_q) * 33'(DIV100_MUL);
    prod_y = 33'(yp1_q) * 33'(DIV100_MUL);
  end

  always_comb begin
    div100   = yp2_q == (KP_W'(qy2_q) * KP_W'(HUNDRED));
    leap     = (yp2_q[1:0] == 2'b00) && (!div100 || (qy2_q[1:0] == 2'b00));
    mlen_eff = (m2_q == 4'(MONTH_FEB) && leap) ? 5'(FEB_LEAP_DAYS) : ml2_q;
    bad_day  = (d2_q == 5'd0) || (d2_q > mlen_eff);
    st_fin   = (st2_q == ST_OK && bad_day) ? ST_BAD_DAY : st2_q;
    c_inc    = 11'(qk2_q) + 11'd1;
    c_x3     = c_inc * 11'd3;
    jd_w     = 25'(t1_2_q[25:2]) + 25'(mt2_q) - 25'(c_x3[10:2]) + 25'(d2_q)
             - 25'(JD_OFFSET);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= date_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && date_i.valid) begin
      yp1_q <= yp0;
      kp1_q <= kp0;
      m1_q  <= date_i.greg_month;
      d1_q  <= date_i.greg_day;
      st1_q <= st0;
    end
    if (en2 && v1_q) begin
      t1_2_q <= t1;
      qk2_q  <= prod_k[DIV100_SHIFT +: Q_W];
      qy2_q  <= prod_y[DIV100_SHIFT +: Q_W];
      yp2_q  <= yp1_q;
      mt2_q  <= month_term(m1_q);
      ml2_q  <= month_len(m1_q);
      m2_q   <= m1_q;
      d2_q   <= d1_q;
      st2_q  <= st1_q;
    end
    if (en3 && v2_q) begin
      w3_q.jd     <= jd_w[JD_W-1:0];
      w3_q.status <= st_fin;
    end
  end

  assign out_valid_o = v3_q;
  assign out_word_o  = w3_q;

endmodule
`default_nettype wire

// File: src/gdyd_split.sv
// last four stages: day number to aligned year and day in year
`default_nettype none
module gdyd_split
  import gdyd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire jdn_word_t in_word_i,
  gdyd_out_if.source     result_o
);

  logic en4, en5, en6, en7;
  logic v4_q, v5_q, v6_q, v7_q;

  // stage 3 logic
  logic [JD_W-1:0]       x3;
  logic [DIV1461_PW-1:0] p3;

  // stage 4
  logic [JD_W-1:0] x4_q;
  logic [K2_W-1:0] q4_q;
  status_e         st4_q;
  logic [JD_W-1:0] l_w;

  // stage 5
  logic [L_W-1:0]  l5_q;
  logic [K2_W-1:0] k5_q;
  status_e         st5_q;
  logic [2:0]      n_cnt;
  logic [1:0]      n5;
  logic [10:0]     v5;
  logic [15:0]     v80;
  logic            t5;

  // stage 6
  logic [L_W-1:0]  l6_q;
  logic [K2_W-1:0] k6_q;
  logic [1:0]      n6_q;
  logic            t6_q;
  status_e         st6_q;
  logic [2:0]      s6;
  logic [11:0]     nd_w;
  logic [17:0]     ny_w;
  logic            zero6;

  // output register
  logic [16:0] ny7_q;
  logic [8:0]  nd7_q;
  status_e     st7_q;

  assign en7 = !v7_q || result_o.ready;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o = en4;

  always_comb begin
    x3 = in_word_i.jd - JD_W'(1);
    p3 = DIV1461_PW'(x3) * DIV1461_PW'(DIV1461_MUL);
  end

  always_comb begin
    l_w = x4_q + JD_W'(1) - (JD_W'(q4_q) * JD_W'(CYC4_DAYS));
  end

  always_comb begin
    n_cnt = 3'(l5_q > L_W'(YEAR_DAYS)) + 3'(l5_q > L_W'(2 * YEAR_DAYS))
          + 3'(l5_q > L_W'(3 * YEAR_DAYS)) + 3'(l5_q > L_W'(4 * YEAR_DAYS))
          - 3'(l5_q == L_W'(CYC4_DAYS));
    n5  = n_cnt[1:0];
    v5  = 11'(l5_q) - (11'(n5) * 11'(YEAR_DAYS)) + 11'(MONTH_SHIFT);
    v80 = 16'(v5) * 16'(T_MUL);
    t5  = v80 >= 16'(T_LIMIT);
  end

  always_comb begin
    s6    = 3'(n6_q) + 3'(t6_q);
    nd_w  = 12'(DAY_BASE) + 12'(l6_q) - (12'(s6) * 12'(YEAR_DAYS))
          + 12'((n6_q == 2'd0) && !t6_q);
    ny_w  = 18'({k6_q, 2'b00}) + 18'(s6) - 18'(EPOCH_YEAR);
    zero6 = (st6_q == ST_BAD_YEAR) || (st6_q == ST_BAD_MONTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      x4_q  <= x3;
      q4_q  <= p3[DIV1461_SHIFT +: K2_W];
      st4_q <= in_word_i.status;
    end
    if (en5 && v4_q) begin
      l5_q  <= l_w[L_W-1:0];
      k5_q  <= q4_q;
      st5_q <= st4_q;
    end
    if (en6 && v5_q) begin
      l6_q  <= l5_q;
      k6_q  <= k5_q;
      n6_q  <= n5;
      t6_q  <= t5;
      st6_q <= st5_q;
    end
    if (en7 && v6_q) begin
      ny7_q <= zero6 ? 17'd0 : ny_w[16:0];
      nd7_q <= zero6 ? 9'd0 : nd_w[8:0];
      st7_q <= st6_q;
    end
  end

  assign result_o.valid        = v7_q;
  assign result_o.aligned_year = signed'(ny7_q);
  assign result_o.day_of_year  = nd7_q;
  assign result_o.status       = st7_q;

endmodule
`default_nettype wire

// File: src/gregorian_date_to_year_day_unit.sv
// throughput: one word per cycle while the result side is ready; each of the seven stages stalls on its own
// the widest stage holds the 24 x 25 bit reciprocal multiply for the four-year split
// reset clears every stage valid bit and sets the century default to enabled
// top level of the gregorian date to aligned year and day in year converter
`default_nettype none
module gregorian_date_to_year_day_unit
  import gdyd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  gdyd_in_if.sink    date_i,
  gdyd_out_if.source result_o
);

  logic      cen_q;
  logic      mid_valid;
  logic      mid_ready;
  jdn_word_t mid_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= 1'b1;
    end else if (cfg_we_i) begin
      cen_q <= cfg_wdata_i;
    end
  end

  gdyd_jdn u_jdn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cen_i       (cen_q),
    .date_i      (date_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_word_o  (mid_word)
  );

  gdyd_split u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (mid_valid),
    .in_ready_o (mid_ready),
    .in_word_i  (mid_word),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire

// File: src/gdyd_checker.sv
// port-level checks on the converter, bound to the top level
`default_nettype none
`include "gregorian_date_to_year_day_unit_macros.svh"
module gdyd_checker
  import gdyd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [16:0] aligned_year_i,
  input wire logic [8:0]  day_of_year_i,
  input wire logic [1:0]  status_i
);

  // a stalled result word holds
  `GDYD_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(aligned_year_i) && $stable(day_of_year_i) && $stable(status_i))

  // year or month error words carry zero year and day
  `GDYD_ASSERT_IMP(a_err_zero, out_valid_i && (status_i == ST_BAD_YEAR || status_i == ST_BAD_MONTH), aligned_year_i == 17'd0 && day_of_year_i == 9'd0)

  // converted words land inside the year
  `GDYD_ASSERT_IMP(a_day_range, out_valid_i && (status_i == ST_OK || status_i == ST_BAD_DAY), day_of_year_i >= 9'd1 && day_of_year_i <= 9'd366)

  // an empty output stage means the whole pipe can move
  `GDYD_ASSERT_IMP(a_ready_empty, !out_valid_i, in_ready_i)

endmodule

bind gregorian_date_to_year_day_unit gdyd_checker u_gdyd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (date_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .aligned_year_i (result_o.aligned_year),
  .day_of_year_i  (result_o.day_of_year),
  .status_i       (result_o.status)
);
`default_nettype wire

// File: bench/gdyd_tb_pkg.sv
// scoreboard for the date conversion bench: expected words and the conversion predictor
`timescale 1ns / 1ps
package gdyd_tb_pkg;
  import gdyd_pkg::status_e;
  import gdyd_pkg::ST_OK;
  import gdyd_pkg::ST_BAD_YEAR;
  import gdyd_pkg::ST_BAD_MONTH;
  import gdyd_pkg::ST_BAD_DAY;

  typedef struct packed {
    logic signed [16:0] year;
    logic [8:0]         yday;
    status_e            status;
  } year_day_t;

  class year_day_scoreboard;
    year_day_t expected_q[$];
    bit        century_on = 1'b1;
    int        errors     = 0;

    function automatic year_day_t convert(input logic signed [15:0] yr_in,
                                          input logic [3:0] mo, input logic [4:0] dy);
      longint    y, m, d, a, k, jd, l, n, t, s, nd, ny, mlen;
      bit        leap;
      year_day_t r;
      y = yr_in;
      m = mo;
      d = dy;
      if (century_on) begin
        if (y >= 0 && y <= 49) y += 2000;
        else if (y >= 50 && y <= 99) y += 1900;
      end
      if (y < -4711) begin
        r.year = '0;
        r.yday = '0;
        r.status = ST_BAD_YEAR;
        return r;
      end
      if (m < 1 || m > 12) begin
        r.year = '0;
        r.yday = '0;
        r.status = ST_BAD_MONTH;
        return r;
      end
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      if (m == 2) mlen = leap ? 29 : 28;
      else if (m == 4 || m == 6 || m == 9 || m == 11) mlen = 30;
      else mlen = 31;
      r.status = (d < 1 || d > mlen) ? ST_BAD_DAY : ST_OK;
      // gregorian date to day number
      a  = (14 - m) / 12;
      k  = y - a;
      jd = (1461 * (k + 4800)) / 4 + (367 * (m - 2 + 12 * a)) / 12
         - (3 * ((k + 4900) / 100)) / 4 + d - 30660;
      // day number back to julian year and day in year
      k  = (jd - 1) / 1461;
      l  = jd - 1461 * k;
      n  = (l - 1) / 365 - l / 1461;
      t  = ((80 * (l - 365 * n + 30)) / 2447) / 11;
      s  = n + t;
      nd = 59 + (l - 365 * s + ((4 - n) / 4) * (1 - t));
      ny = 4 * k + s - 4716;
      r.year = ny[16:0];
      r.yday = nd[8:0];
      return r;
    endfunction

    function automatic void note_date(input logic signed [15:0] y, input logic [3:0] m,
                                      input logic [4:0] d);
      expected_q.push_back(convert(y, m, d));
    endfunction

    function automatic void check_result(input logic signed [16:0] y, input logic [8:0] yd,
                                         input logic [1:0] st);
      year_day_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: year %0d day %0d status %0d", y, yd, st);
        return;
      end
      exp_w = expected_q.pop_front();
      if (exp_w.year !== y || exp_w.yday !== yd || exp_w.status !== st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected year %0d day %0d status %0d, got year %0d day %0d status %0d",
                   $signed(exp_w.year), exp_w.yday, exp_w.status, y, yd, st);
      end
    endfunction

    function automatic int pending();
      return expected_q.size();
    endfunction
  endclass
endpackage

// File: bench/tb_gregorian_date_to_year_day_unit.sv
// top of the date conversion bench: clock, reset, drivers, monitor and run sequence
`timescale 1ns / 1ps
module tb_gregorian_date_to_year_day_unit;
  import gdyd_tb_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 100;
  localparam int PHASE_WORDS = 375;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  gdyd_in_if  date_if ();
  gdyd_out_if res_if ();

  gregorian_date_to_year_day_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .date_i      (date_if),
    .result_o    (res_if)
  );

  year_day_scoreboard sb;
  int send_pct  = 0;
  int recv_pct  = 0;
  bit hold_req  = 1'b0;
  int idle_cnt  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side, with the long hold-off when asked
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (date_if.valid && date_if.ready)
        sb.note_date(date_if.greg_year, date_if.greg_month, date_if.greg_day);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.aligned_year, res_if.day_of_year, res_if.status);
      if ((date_if.valid && date_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  task automatic send_date(input logic signed [15:0] y, input logic [3:0] m,
                           input logic [4:0] d);
    while ($urandom_range(99) < send_pct) begin
      date_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    date_if.valid      <= 1'b1;
    date_if.greg_year  <= y;
    date_if.greg_month <= m;
    date_if.greg_day   <= d;
    @(posedge clk_i);
    while (!date_if.ready) @(posedge clk_i);
  endtask

  task automatic set_century(input bit enable);
    date_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.century_on = enable;
  endtask

  task automatic send_random(input int count);
    logic [31:0]        r;
    logic signed [15:0] y;
    logic [3:0]         m;
    logic [4:0]         d;
    int                 mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      r = $urandom();
      if (mode < 2) y = r[15:0];
      else if (mode < 4) y = 16'($urandom_range(120));
      else if (mode == 4) y = 16'(-4720 + int'($urandom_range(20)));
      else y = 16'($urandom_range(2110, 1890));
      if ($urandom_range(99) < 90) m = 4'($urandom_range(12, 1));
      else m = 4'($urandom_range(15));
      if ($urandom_range(99) < 70) d = 5'($urandom_range(28, 1));
      else d = 5'($urandom_range(31));
      send_date(y, m, d);
    end
  endtask

  initial begin
    sb = new();
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 1'b0;
    date_if.valid      <= 1'b0;
    date_if.greg_year  <= '0;
    date_if.greg_month <= '0;
    date_if.greg_day   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pct = 19;
    recv_pct = 64;
    // directed dates, century default still at its reset value
    send_date(2000, 2, 29);
    send_date(1900, 2, 29);
    send_date(2100, 2, 29);
    send_date(2024, 12, 31);
    send_date(2023, 1, 1);
    send_date(0, 1, 1);
    send_date(49, 6, 15);
    send_date(50, 6, 15);
    send_date(99, 12, 31);
    send_date(100, 3, 1);
    send_date(-1, 1, 1);
    send_date(-4711, 1, 1);
    send_date(-4712, 1, 1);
    send_date(-32768, 5, 5);
    send_date(32767, 12, 31);
    send_date(2001, 0, 1);
    send_date(2001, 13, 1);
    send_date(2001, 15, 31);
    send_date(-4712, 0, 0);
    send_date(2001, 4, 31);
    send_date(2001, 3, 0);
    send_date(2001, 1, 0);
    send_date(1999, 2, 28);

    set_century(1'b0);
    send_random(PHASE_WORDS);

    set_century(1'b1);
    send_pct = 64;
    recv_pct = 19;
    send_random(PHASE_WORDS);

    set_century(1'b0);
    send_pct = 0;
    recv_pct = 0;
    hold_req = 1'b1;
    send_random(PHASE_WORDS);

    set_century(1'b1);
    send_random(PHASE_WORDS);

    date_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: gregorian_date_to_year_day_unit.f
+incdir+src
src/gdyd_pkg.sv
src/gdyd_in_if.sv
src/gdyd_out_if.sv
src/gdyd_jdn.sv
src/gdyd_split.sv
src/gregorian_date_to_year_day_unit.sv
src/gdyd_checker.sv
bench/gdyd_tb_pkg.sv
bench/tb_gregorian_date_to_year_day_unit.sv
